// File: rtl/izn_pkg.sv
// Shared types, constants and helper functions for the Izhikevich neuron step block.
// No dependencies; every other file in rtl imports this package.
`default_nettype none

package izn_pkg;

  localparam int INDEX_W   = 10;
  localparam int IDX_RANGE = 1 << INDEX_W;
  localparam int VAL_W     = 24;
  localparam int TRACE_W   = 16;

  localparam int EXC_COUNT       = 120;
  localparam int NON_INPUT_COUNT = 240;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [TRACE_W-1:0] trace_t;
  typedef logic [INDEX_W-1:0] index_t;

  typedef enum logic [1:0] {
    CFG_EXC_THRESHOLD   = 2'd0,
    CFG_EXC_RESET_LEVEL = 2'd1,
    CFG_INH_THRESHOLD   = 2'd2,
    CFG_INH_RESET_LEVEL = 2'd3
  } cfg_index_t;

  typedef struct packed {
    val_t   membrane;
    val_t   recovery;
    trace_t ltp;
    trace_t ltd;
  } mem_word_t;

  typedef struct packed {
    index_t neuron_id;
    logic   spiked;
    val_t   membrane;
    trace_t ltp;
    trace_t ltd;
  } result_t;

  localparam val_t MEMBRANE_RESET  = -24'sd16640;
  localparam val_t RECOVERY_RESET  = -24'sd3328;
  localparam val_t THRESHOLD_RESET = 24'sd7680;
  localparam val_t INPUT_THRESHOLD = 24'sd7680;
  localparam val_t INPUT_RESET     = -24'sd16640;
  localparam val_t INJECT_LEVEL    = 24'sd12800;
  localparam val_t D_EXC           = 24'sd2048;
  localparam val_t D_INH           = 24'sd512;
  localparam trace_t LTP_SET       = 16'd6554;
  localparam trace_t LTD_SET       = 16'd7864;

  // Half step: 5v + 140 - u + I carries the constant 140 in Q15.8.
  localparam logic signed [27:0] LIN_BIAS = 28'sd35840;
  localparam logic [47:0] SQ_ROUND = 48'd3200;
  // Above this quotient bound the half step saturates high whatever the other terms are.
  localparam logic [31:0] SQ_X_CAP = 32'd3355443199;

  // floor(x / 25) and floor(x / 125) for any 32-bit x: (x * magic) >> 35.
  localparam logic [30:0] DIV25_MAGIC  = 31'h51EB851F;
  localparam logic [30:0] DIV125_MAGIC = 31'h10624DD3;
  localparam int DIV_SHIFT = 35;

  // Recovery rounding bias plus an offset of den * 2^20 that keeps the dividend positive.
  localparam logic signed [29:0] REC_BIAS_50  = 30'sd52428825;
  localparam logic signed [29:0] REC_BIAS_250 = 30'sd262144125;
  localparam logic signed [25:0] REC_OFFSET_Q = 26'sd1048576;

  // floor(x / 5) for x below 2^19: (x * magic) >> 21.
  localparam logic [18:0] DECAY_MAGIC = 19'd419431;

  function automatic val_t sat24(input logic signed [31:0] x);
    val_t r;
    if (x > 32'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (x < -32'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = x[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/izn_state_mem.sv
// Per-neuron state memory: membrane, recovery and both traces in one word.
// One write port and one read port with registered read data; uses izn_pkg.
`default_nettype none

module izn_state_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [ADDR_W-1:0]      wr_addr,
  input  izn_pkg::mem_word_t     wr_data,
  input  logic [ADDR_W-1:0]      rd_addr,
  output izn_pkg::mem_word_t     rd_data
);
  import izn_pkg::*;

  mem_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/izn_half_step.sv
// One half-millisecond membrane update in four pipeline stages:
// v + floor((round(v*v/6400) + 5v + 140 - u + I) / 2), saturated. Uses izn_pkg.
`default_nettype none

module izn_half_step (
  input  logic         clk,
  input  izn_pkg::val_t v_in,
  input  izn_pkg::val_t u_in,
  input  izn_pkg::val_t cur_in,
  output izn_pkg::val_t v_out,
  output izn_pkg::val_t u_out,
  output izn_pkg::val_t cur_out
);
  import izn_pkg::*;

  logic signed [47:0] sq_w;
  logic signed [27:0] lin_w;
  val_t a_v, a_u, a_cur;
  logic [46:0] a_sq;
  logic signed [27:0] a_lin;

  logic [47:0] sum_w;
  logic [39:0] xs_w;
  val_t b_v, b_u, b_cur;
  logic signed [27:0] b_lin;
  logic [31:0] b_x;

  logic [62:0] prod_w;
  val_t c_v, c_u, c_cur;
  logic signed [27:0] c_lin;
  logic [62:0] c_prod;

  logic signed [28:0] f_w;
  logic signed [28:0] half_w;
  logic signed [31:0] vsum_w;

  assign sq_w  = v_in * v_in;
  assign lin_w = (28'(v_in) <<< 2) + 28'(v_in) - 28'(u_in) + 28'(cur_in) + LIN_BIAS;

  always_ff @(posedge clk) begin
    a_v   <= v_in;
    a_u   <= u_in;
    a_cur <= cur_in;
    a_sq  <= sq_w[46:0];
    a_lin <= lin_w;
  end

  assign sum_w = {1'b0, a_sq} + SQ_ROUND;
  assign xs_w  = sum_w[47:8];

  always_ff @(posedge clk) begin
    b_v   <= a_v;
    b_u   <= a_u;
    b_cur <= a_cur;
    b_lin <= a_lin;
    b_x   <= (xs_w > 40'(SQ_X_CAP)) ? SQ_X_CAP : xs_w[31:0];
  end

  assign prod_w = b_x * DIV25_MAGIC;

  always_ff @(posedge clk) begin
    c_v    <= b_v;
    c_u    <= b_u;
    c_cur  <= b_cur;
    c_lin  <= b_lin;
    c_prod <= prod_w;
  end

  assign f_w    = signed'({1'b0, c_prod[62:DIV_SHIFT]}) + 29'(c_lin);
  assign half_w = f_w >>> 1;
  assign vsum_w = 32'(c_v) + 32'(half_w);

  always_ff @(posedge clk) begin
    v_out   <= sat24(vsum_w);
    u_out   <= c_u;
    cur_out <= c_cur;
  end

endmodule

`default_nettype wire

// File: rtl/izn_recovery.sv
// Recovery update in three pipeline stages: u + round((v - 5u) / den), saturated,
// with den 50 for inhibitory neurons and 250 otherwise. Uses izn_pkg.
`default_nettype none

module izn_recovery (
  input  logic          clk,
  input  izn_pkg::val_t v_in,
  input  izn_pkg::val_t u_in,
  input  logic          slow,
  output izn_pkg::val_t v_out,
  output izn_pkg::val_t u_out
);
  import izn_pkg::*;

  logic signed [29:0] five_u_w;
  logic signed [29:0] z_w;
  val_t a_v, a_u;
  logic a_slow;
  logic [27:0] a_w;

  logic [58:0] prod_w;
  val_t b_v, b_u;
  logic [58:0] b_prod;

  logic signed [25:0] r_w;
  logic signed [31:0] usum_w;

  assign five_u_w = (30'(u_in) <<< 2) + 30'(u_in);
  assign z_w = 30'(v_in) - five_u_w + (slow ? REC_BIAS_50 : REC_BIAS_250);

  always_ff @(posedge clk) begin
    a_v    <= v_in;
    a_u    <= u_in;
    a_slow <= slow;
    a_w    <= z_w[28:1];
  end

  assign prod_w = a_w * (a_slow ? DIV25_MAGIC : DIV125_MAGIC);

  always_ff @(posedge clk) begin
    b_v    <= a_v;
    b_u    <= a_u;
    b_prod <= prod_w;
  end

  assign r_w    = signed'({2'b00, b_prod[58:DIV_SHIFT]}) - REC_OFFSET_Q;
  assign usum_w = 32'(b_u) + 32'(r_w);

  always_ff @(posedge clk) begin
    v_out <= b_v;
    u_out <= sat24(usum_w);
  end

endmodule

`default_nettype wire

// File: rtl/izn_out_fifo.sv
// Result queue between the update pipeline and the output channel.
// Holds FIFO_DEPTH items; the head is shown while the queue is not empty. Uses izn_pkg.
`default_nettype none

module izn_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  izn_pkg::result_t  push_data,
  input  logic              pop,
  output logic              valid,
  output izn_pkg::result_t  head
);
  import izn_pkg::*;

  result_t entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [OCC_W-1:0] count;

  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/izhikevich_neuron_step.sv
// Izhikevich neuron step: top level with state memory, update pipeline and result queue.
// One item is accepted per cycle unless in_stall holds it off. An item for a neuron that is
// still in the 13-stage read-modify-write pipeline waits until that earlier item has
// written its state back.
// After reset a clearing pass writes the reset state to every memory entry; no item is
// accepted during that pass. Depends on izn_pkg.
`default_nettype none

module izhikevich_neuron_step #(
  parameter int NEURON_COUNT = 1024
) (
  input  logic                clk,
  input  logic                rst,

  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,

  input  logic                in_valid,
  output logic                in_stall,
  input  izn_pkg::index_t     neuron_index,
  input  izn_pkg::val_t       input_current,
  input  logic                learning,
  input  logic                inject,

  output logic                out_valid,
  input  logic                out_stall,
  output izn_pkg::index_t     neuron_id,
  output logic                spiked,
  output izn_pkg::val_t       membrane_out,
  output izn_pkg::trace_t     ltp_out,
  output izn_pkg::trace_t     ltd_out
);
  import izn_pkg::*;

  localparam int DEPTH    = (NEURON_COUNT < IDX_RANGE) ? NEURON_COUNT : IDX_RANGE;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int PIPE_LEN = 12;
  localparam int REC_TAP  = 8;

  typedef struct packed {
    index_t idx;
    logic   in_range;
    logic   slow;
    logic   spiked;
    trace_t ltp;
    trace_t ltd;
  } side_t;

  function automatic trace_t trace_decay(input trace_t t);
    logic [20:0] x;
    logic [37:0] p;
    x = 21'(t) * 21'd19 + 21'd10;
    p = 38'(x[20:2]) * 38'(DECAY_MAGIC);
    return p[36:21];
  endfunction

  val_t exc_threshold, exc_reset_level, inh_threshold, inh_reset_level;

  logic clr_busy;
  logic [ADDR_W-1:0] clr_addr;

  logic accept;
  logic pop;
  logic conflict;
  logic [OCC_W-1:0] occ;

  logic   s1_vld;
  index_t s1_idx;
  val_t   s1_cur;
  logic   s1_learn;
  logic   s1_inject;
  logic   s1_in_range;

  mem_word_t rd_word;
  mem_word_t wr_word;
  logic wr_en;
  logic [ADDR_W-1:0] wr_addr;

  logic is_exc, is_inh, is_inp;
  val_t thr, rst_level, dstep, v_pre, u_spk;
  logic spk;
  side_t side0_next;
  side_t side1_next;
  val_t v2, u2, cur2;

  side_t side [PIPE_LEN];
  logic [PIPE_LEN-1:0] side_vld;

  val_t h1_v, h1_u, h1_cur;
  val_t h2_v, h2_u, h2_cur;
  val_t rec_v, rec_u;

  result_t res;
  result_t head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      exc_threshold   <= THRESHOLD_RESET;
      exc_reset_level <= MEMBRANE_RESET;
      inh_threshold   <= THRESHOLD_RESET;
      inh_reset_level <= MEMBRANE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_EXC_THRESHOLD:   exc_threshold   <= signed'(cfg_data);
        CFG_EXC_RESET_LEVEL: exc_reset_level <= signed'(cfg_data);
        CFG_INH_THRESHOLD:   inh_threshold   <= signed'(cfg_data);
        CFG_INH_RESET_LEVEL: inh_reset_level <= signed'(cfg_data);
      endcase
    end
  end

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // An item may not enter while the same neuron is anywhere between read and write-back.
  always_comb begin
    conflict = s1_vld && (s1_idx == neuron_index);
    for (int k = 0; k < PIPE_LEN; k++) begin
      if (side_vld[k] && (side[k].idx == neuron_index)) begin
        conflict = 1'b1;
      end
    end
  end

  assign in_stall = clr_busy || conflict || (occ >= OCC_W'(FIFO_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      case ({accept, pop})
        2'b10:   occ <= occ + 1'b1;
        2'b01:   occ <= occ - 1'b1;
        default: occ <= occ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
    s1_idx      <= neuron_index;
    s1_cur      <= input_current;
    s1_learn    <= learning;
    s1_inject   <= inject;
    s1_in_range <= (32'(neuron_index) < NEURON_COUNT);
  end

  always_comb begin
    if (clr_busy) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_word = '{membrane: MEMBRANE_RESET, recovery: RECOVERY_RESET, ltp: '0, ltd: '0};
    end else begin
      wr_en   = side_vld[PIPE_LEN-1] && side[PIPE_LEN-1].in_range;
      wr_addr = side[PIPE_LEN-1].idx[ADDR_W-1:0];
      wr_word = '{membrane: rec_v, recovery: rec_u,
                  ltp: side[PIPE_LEN-1].ltp, ltd: side[PIPE_LEN-1].ltd};
    end
  end

  izn_state_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_addr (neuron_index[ADDR_W-1:0]),
    .rd_data (rd_word)
  );

  // Threshold check and spike reset.
  always_comb begin
    is_exc = (32'(s1_idx) < EXC_COUNT);
    is_inh = !is_exc && (32'(s1_idx) < NON_INPUT_COUNT);
    is_inp = !is_exc && !is_inh;
    if (is_exc) begin
      thr       = exc_threshold;
      rst_level = exc_reset_level;
      dstep     = D_EXC;
    end else if (is_inh) begin
      thr       = inh_threshold;
      rst_level = inh_reset_level;
      dstep     = D_INH;
    end else begin
      thr       = INPUT_THRESHOLD;
      rst_level = INPUT_RESET;
      dstep     = D_EXC;
    end
    v_pre = (is_inp && s1_inject) ? INJECT_LEVEL : rd_word.membrane;
    spk   = s1_in_range && (v_pre >= thr);
    u_spk = sat24(32'(rd_word.recovery) + 32'(dstep));

    side0_next.idx      = s1_idx;
    side0_next.in_range = s1_in_range;
    side0_next.slow     = is_inh;
    side0_next.spiked   = spk;
    if (!s1_in_range) begin
      side0_next.ltp = '0;
      side0_next.ltd = '0;
    end else if (spk && !is_inp && s1_learn) begin
      side0_next.ltp = LTP_SET;
      side0_next.ltd = LTD_SET;
    end else begin
      side0_next.ltp = rd_word.ltp;
      side0_next.ltd = rd_word.ltd;
    end
  end

  always_ff @(posedge clk) begin
    v2   <= spk ? rst_level : v_pre;
    u2   <= spk ? u_spk : rd_word.recovery;
    cur2 <= s1_cur;
  end

  always_comb begin
    side1_next     = side[0];
    side1_next.ltp = trace_decay(side[0].ltp);
    side1_next.ltd = trace_decay(side[0].ltd);
  end

  // Item bookkeeping alongside the arithmetic; traces decay in the first step.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_vld <= '0;
    end else begin
      side_vld <= {side_vld[PIPE_LEN-2:0], s1_vld};
    end
    side[0] <= side0_next;
    side[1] <= side1_next;
    for (int k = 2; k < PIPE_LEN; k++) begin
      side[k] <= side[k-1];
    end
  end

  izn_half_step u_half1 (
    .clk     (clk),
    .v_in    (v2),
    .u_in    (u2),
    .cur_in  (cur2),
    .v_out   (h1_v),
    .u_out   (h1_u),
    .cur_out (h1_cur)
  );

  izn_half_step u_half2 (
    .clk     (clk),
    .v_in    (h1_v),
    .u_in    (h1_u),
    .cur_in  (h1_cur),
    .v_out   (h2_v),
    .u_out   (h2_u),
    .cur_out (h2_cur)
  );

  izn_recovery u_rec (
    .clk   (clk),
    .v_in  (h2_v),
    .u_in  (h2_u),
    .slow  (side[REC_TAP].slow && (h2_cur == h2_cur)),
    .v_out (rec_v),
    .u_out (rec_u)
  );

  always_comb begin
    res.neuron_id = side[PIPE_LEN-1].idx;
    res.spiked    = side[PIPE_LEN-1].spiked;
    res.membrane  = side[PIPE_LEN-1].in_range ? rec_v : '0;
    res.ltp       = side[PIPE_LEN-1].ltp;
    res.ltd       = side[PIPE_LEN-1].ltd;
  end

  izn_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (side_vld[PIPE_LEN-1]),
    .push_data (res),
    .pop       (pop),
    .valid     (out_valid),
    .head      (head)
  );

  assign neuron_id    = head.neuron_id;
  assign spiked       = head.spiked;
  assign membrane_out = head.membrane;
  assign ltp_out      = head.ltp;
  assign ltd_out      = head.ltd;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for izhikevich_neuron_step: a queue-fed driver with bursty timing,
// a receiver with its own stall pattern, and a fixed-point neuron model that predicts each result.
// Depends on izn_pkg and the izhikevich_neuron_step RTL.
`default_nettype none

module tb_top;
  import izn_pkg::*;

  localparam int NEURONS     = 1024;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    index_t idx;
    val_t   current;
    logic   learn;
    logic   inj;
  } stim_item_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN, RX_HEAVY} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = CFG_EXC_THRESHOLD;
  logic [23:0] cfg_data = '0;

  logic   in_valid = 1'b0;
  logic   in_stall;
  index_t neuron_index = '0;
  val_t   input_current = '0;
  logic   learning = 1'b0;
  logic   inject = 1'b0;

  logic   out_valid;
  logic   out_stall = 1'b0;
  index_t neuron_id;
  logic   spiked;
  val_t   membrane_out;
  trace_t ltp_out;
  trace_t ltd_out;

  izhikevich_neuron_step #(.NEURON_COUNT(NEURONS)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .neuron_index(neuron_index), .input_current(input_current),
    .learning(learning), .inject(inject),
    .out_valid(out_valid), .out_stall(out_stall),
    .neuron_id(neuron_id), .spiked(spiked), .membrane_out(membrane_out),
    .ltp_out(ltp_out), .ltd_out(ltd_out)
  );

  always #1 clk = ~clk;

  // Model copy of the neuron memory and the threshold and reset level registers.
  val_t   nrn_v [NEURONS];
  val_t   nrn_u [NEURONS];
  trace_t nrn_ltp [NEURONS];
  trace_t nrn_ltd [NEURONS];
  val_t   exc_thr, exc_lvl, inh_thr, inh_lvl;

  stim_item_t pending_items[$];
  result_t    expected_results[$];
  int         items_queued = 0;
  int         items_accepted = 0;
  int         errors = 0;
  int         cycle_count = 0;
  bit         item_taken = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;
  stim_item_t next_item;
  result_t    want;
  index_t     last_idx = '0;

  bit       hold_go = 1'b0;
  bit       hold_done = 1'b0;
  int       hold_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  int       rx_mode_left = 0;
  int       rx_pattern_pos = 0;

  function automatic longint floor_div(longint x, longint d);
    if (x >= 0) begin
      return x / d;
    end
    return -((-x + d - 1) / d);
  endfunction

  function automatic longint round_div(longint x, longint d);
    return floor_div(x + d / 2, d);
  endfunction

  function automatic val_t clamp24(longint x);
    if (x > 64'sd8388607) begin
      return 24'sh7FFFFF;
    end
    if (x < -64'sd8388608) begin
      return 24'sh800000;
    end
    return val_t'(x);
  endfunction

  function automatic val_t membrane_half_ms(val_t v, val_t u, val_t cur);
    longint vv;
    longint f;
    vv = longint'(v);
    f = round_div(vv * vv, 6400) + 5 * vv + 140 * 256 - longint'(u) + longint'(cur);
    return clamp24(vv + floor_div(f, 2));
  endfunction

  function automatic trace_t decay_trace(trace_t t);
    int unsigned x;
    x = (32'(t) * 19 + 10) / 20;
    return trace_t'(x);
  endfunction

  function automatic result_t step_neuron(index_t idx, val_t cur, logic learn, logic inj);
    result_t r;
    val_t    v, u, thr, lvl;
    longint  dstep, den;
    logic    sets_traces;
    trace_t  p, d;
    r = '0;
    r.neuron_id = idx;
    if (int'(idx) >= NEURONS) begin
      return r;
    end
    v = nrn_v[idx];
    u = nrn_u[idx];
    p = nrn_ltp[idx];
    d = nrn_ltd[idx];
    sets_traces = 1'b1;
    if (int'(idx) < EXC_COUNT) begin
      thr = exc_thr; lvl = exc_lvl; dstep = 2048; den = 250;
    end else if (int'(idx) < NON_INPUT_COUNT) begin
      thr = inh_thr; lvl = inh_lvl; dstep = 512; den = 50;
    end else begin
      thr = INPUT_THRESHOLD; lvl = INPUT_RESET; dstep = 2048; den = 250;
      sets_traces = 1'b0;
      if (inj) begin
        v = INJECT_LEVEL;
      end
    end
    if (v >= thr) begin
      r.spiked = 1'b1;
      v = lvl;
      u = clamp24(longint'(u) + dstep);
      if (sets_traces && learn) begin
        p = LTP_SET;
        d = LTD_SET;
      end
    end
    v = membrane_half_ms(v, u, cur);
    v = membrane_half_ms(v, u, cur);
    u = clamp24(longint'(u) + round_div(longint'(v) - 5 * longint'(u), den));
    p = decay_trace(p);
    d = decay_trace(d);
    nrn_v[idx] = v;
    nrn_u[idx] = u;
    nrn_ltp[idx] = p;
    nrn_ltd[idx] = d;
    r.membrane = v;
    r.ltp = p;
    r.ltd = d;
    return r;
  endfunction

  task automatic compare_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  task automatic queue_item(int idx, int cur, bit learn, bit inj);
    stim_item_t s;
    s.idx = index_t'(idx);
    s.current = val_t'(cur);
    s.learn = learn;
    s.inj = inj;
    pending_items.insert(pending_items.size(), s);
    items_queued++;
  endtask

  task automatic queue_random(int count);
    int     hot [12];
    int     idx, cur, pick;
    bit     learn, inj;
    hot = '{0, 1, EXC_COUNT - 1, 60, EXC_COUNT, EXC_COUNT + 1, 200, NON_INPUT_COUNT - 1,
            NON_INPUT_COUNT, NON_INPUT_COUNT + 1, 700, 1023};
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        idx = hot[$urandom_range(11)];
      end else if (pick < 65) begin
        idx = int'(last_idx);
      end else begin
        idx = $urandom_range(1023);
      end
      last_idx = index_t'(idx);
      pick = $urandom_range(99);
      if (pick < 55) begin
        cur = int'($urandom_range(5632)) - 512;
      end else if (pick < 70) begin
        cur = int'($urandom_range(40000)) - 20000;
      end else if (pick < 80) begin
        case ($urandom_range(4))
          0: cur = 8388607;
          1: cur = -8388608;
          2: cur = 0;
          3: cur = -1;
          default: cur = 1;
        endcase
      end else begin
        cur = int'($urandom());
      end
      learn = ($urandom_range(9) < 7);
      inj = (idx >= NON_INPUT_COUNT) ? ($urandom_range(4) == 0) : bit'($urandom_range(1));
      queue_item(idx, cur, learn, inj);
    end
  endtask

  task automatic write_registers(val_t et, val_t el, val_t it, val_t il);
    @(negedge clk);
    cfg_write <= 1'b1; cfg_index <= CFG_EXC_THRESHOLD; cfg_data <= et;
    exc_thr = et;
    @(negedge clk);
    cfg_index <= CFG_EXC_RESET_LEVEL; cfg_data <= el;
    exc_lvl = el;
    @(negedge clk);
    cfg_index <= CFG_INH_THRESHOLD; cfg_data <= it;
    inh_thr = it;
    @(negedge clk);
    cfg_index <= CFG_INH_RESET_LEVEL; cfg_data <= il;
    inh_lvl = il;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic val_t realistic_threshold();
    return val_t'(int'($urandom_range(20 * 256, 35 * 256)));
  endfunction

  function automatic val_t realistic_level();
    return val_t'(-int'($urandom_range(45 * 256, 70 * 256)));
  endfunction

  // Driver: one item per handshake, in bursts separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        next_item = pending_items.pop_front();
        in_valid <= 1'b1;
        neuron_index <= next_item.idx;
        input_current <= next_item.current;
        learning <= next_item.learn;
        inject <= next_item.inj;
        if (burst_left > 0) begin
          burst_left--;
        end
        if (burst_left == 0) begin
          if ($urandom_range(4) == 0) begin
            burst_left = $urandom_range(40, 120);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left = $urandom_range(0, 6);
          end
        end
      end
    end
  end

  // Receiver stall: a long hold when requested, otherwise a changing pattern.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(3));
        rx_mode_left = $urandom_range(40, 160);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_FREE:    out_stall <= 1'b0;
        RX_RANDOM:  out_stall <= ($urandom_range(99) < 30);
        RX_PATTERN: out_stall <= ((rx_pattern_pos % 7) < 3);
        default:    out_stall <= ($urandom_range(99) < 70);
      endcase
      rx_pattern_pos++;
    end
  end

  // Both handshakes are observed at the rising edge.
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && in_valid && !in_stall) begin
      expected_results.insert(expected_results.size(),
                              step_neuron(neuron_index, input_current, learning, inject));
      items_accepted++;
      item_taken = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result for neuron %0d, expected nothing", $time, neuron_id);
        errors++;
      end else begin
        want = expected_results.pop_front();
        compare_field("neuron_id", longint'(want.neuron_id), longint'(neuron_id));
        compare_field("spiked", longint'(want.spiked), longint'(spiked));
        compare_field("membrane_out", longint'(want.membrane), longint'(membrane_out));
        compare_field("ltp_out", longint'(want.ltp), longint'(ltp_out));
        compare_field("ltd_out", longint'(want.ltd), longint'(ltd_out));
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    exc_thr = THRESHOLD_RESET;
    exc_lvl = MEMBRANE_RESET;
    inh_thr = THRESHOLD_RESET;
    inh_lvl = MEMBRANE_RESET;
    for (int k = 0; k < NEURONS; k++) begin
      nrn_v[k] = MEMBRANE_RESET;
      nrn_u[k] = RECOVERY_RESET;
      nrn_ltp[k] = '0;
      nrn_ltd[k] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset thresholds: class boundaries, current extremes, inject cases, back-to-back neurons.
    queue_item(0, 0, 1'b0, 1'b0);
    queue_item(EXC_COUNT - 1, 8388607, 1'b1, 1'b0);
    queue_item(EXC_COUNT, -8388608, 1'b1, 1'b0);
    queue_item(NON_INPUT_COUNT - 1, 2560, 1'b1, 1'b0);
    queue_item(NON_INPUT_COUNT, 0, 1'b1, 1'b1);
    queue_item(1023, -1, 1'b0, 1'b1);
    queue_item(5, 1000, 1'b1, 1'b1);
    queue_item(130, 1000, 1'b1, 1'b1);
    queue_item(EXC_COUNT - 1, 8388607, 1'b1, 1'b0);
    queue_item(EXC_COUNT - 1, -8388608, 1'b0, 1'b0);
    queue_item(1023, 5120, 1'b0, 1'b0);
    queue_item(512, 0, 1'b0, 1'b1);
    queue_item(512, 0, 1'b0, 1'b1);
    queue_item(512, 0, 1'b1, 1'b1);
    queue_random(250);
    wait_drained();

    // Non-input neurons always fire; excitatory ones reset to the top of the range, inhibitory ones to the bottom.
    write_registers(24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh800000);
    queue_item(0, 0, 1'b1, 1'b0);
    queue_item(1, 0, 1'b0, 1'b0);
    queue_item(0, 0, 1'b0, 1'b0);
    queue_item(EXC_COUNT, 0, 1'b1, 1'b0);
    queue_item(EXC_COUNT + 1, 0, 1'b0, 1'b0);
    queue_item(NON_INPUT_COUNT, 0, 1'b1, 1'b0);
    queue_item(NON_INPUT_COUNT + 1, 0, 1'b1, 1'b1);
    queue_random(250);
    wait_drained();

    // Non-input thresholds at the top of the range: they fire only when the membrane is saturated high.
    write_registers(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
    queue_random(250);
    wait_drained();

    write_registers(realistic_threshold(), realistic_level(), realistic_threshold(),
                    realistic_level());
    queue_random(270);
    wait_drained();

    // The receiver holds off while the sender keeps offering items.
    write_registers(realistic_threshold(), realistic_level(), realistic_threshold(),
                    realistic_level());
    hold_go = 1'b1;
    queue_random(270);
    wait_drained();

    write_registers(val_t'($urandom()), val_t'($urandom()), val_t'($urandom()),
                    val_t'($urandom()));
    queue_random(270);
    wait_drained();

    write_registers(THRESHOLD_RESET, MEMBRANE_RESET, THRESHOLD_RESET, MEMBRANE_RESET);
    queue_random(290);
    wait_drained();

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
